// ===== hdl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bisection square root package
// Shared widths, fixed-point constants and register map for the block.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int unsigned DataW   = 32;        // Q20.12 operand width
  localparam int unsigned FracW   = 12;        // fractional bits of Q20.12
  localparam int unsigned SqW     = 2 * DataW; // Q40.24 square width
  localparam int unsigned LimW    = 45;        // target plus tolerance
  localparam int unsigned IterW   = 7;         // iteration count width
  localparam int unsigned AddrW   = 2;         // APB byte address width

  localparam logic [DataW-1:0] FixOne       = 32'd4096;
  localparam logic [DataW-1:0] TolResetVal  = 32'd1677722;
  localparam logic [AddrW-1:0] RegTolerance = 2'd0;

  typedef logic [DataW-1:0] data_t;
  typedef logic [SqW-1:0]   sq_t;
  typedef logic [LimW-1:0]  lim_t;

endpackage

// ===== hdl/bisection_square_root.sv =====
// ----------------------------------------------------------------------------
// Bisection square root
// Finds the Q20.12 square root of a Q20.12 radicand by interval halving,
// squaring each midpoint on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the radicand on value_i; it is taken at a clock edge
//   where busy is low. busy stays high while the search runs.
//   The result (root, final bounds, iteration count, converged flag) is shown
//   for one cycle with done_o high; the receiver takes it in that cycle and
//   cannot hold it off. A new start may be given in that same cycle.
//   A radicand of 0 or 1.0 gives done_o in the cycle after the transfer.
//   Otherwise each halving step squares the midpoint on the shared
//   multiplier, then compares and narrows the interval, and no new
//   radicand is taken until the search ends.
//   The tolerance register sits at byte address 0 of the APB port; write it
//   only while busy is low. Reset sets it to about 0.1 (1677722 * 2^-24),
//   drops busy and done_o, and leaves the block idle.
// ----------------------------------------------------------------------------
module bisection_square_root #(
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [bsr_pkg::DataW-1:0] value_i,
  // result channel
  output logic                      done_o,
  output logic [bsr_pkg::DataW-1:0] root_o,
  output logic [bsr_pkg::DataW-1:0] low_bound_o,
  output logic [bsr_pkg::DataW-1:0] high_bound_o,
  output logic [bsr_pkg::IterW-1:0] iterations_o,
  output logic                      converged_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StCmp
  } state_e;

  localparam logic [bsr_pkg::IterW-1:0] IterMax = bsr_pkg::IterW'(MAX_ITERATIONS);

  state_e            state_q;
  logic              done_q;
  logic              conv_q;
  logic [bsr_pkg::IterW-1:0] iter_q;
  bsr_pkg::data_t    tol_q;
  bsr_pkg::data_t    lo_q;
  bsr_pkg::data_t    hi_q;
  bsr_pkg::data_t    x_q;
  bsr_pkg::sq_t      sq_q;
  bsr_pkg::lim_t     tgt_q;
  bsr_pkg::lim_t     lim_hi_q;
  bsr_pkg::lim_t     lim_lo_q;

  logic              accept;
  logic              cfg_wr;
  bsr_pkg::data_t    hi_init;
  bsr_pkg::lim_t     tgt_new;
  bsr_pkg::lim_t     tol_ext;
  logic              in_window;
  logic              below;
  logic              stop;
  logic [bsr_pkg::DataW:0] sum_lo;
  logic [bsr_pkg::DataW:0] sum_hi;

  // Handshakes
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == bsr_pkg::RegTolerance) ? tol_q : '0;

  // Start-up interval and window limits around the Q40.24 target
  assign hi_init = (value_i > bsr_pkg::FixOne) ? value_i : bsr_pkg::FixOne;
  assign tgt_new = bsr_pkg::LimW'({value_i, {bsr_pkg::FracW{1'b0}}});
  assign tol_ext = bsr_pkg::LimW'(tol_q);

  // Compare the square against the window and target in parallel
  assign in_window = (sq_q <= bsr_pkg::SqW'(lim_hi_q)) && (sq_q >= bsr_pkg::SqW'(lim_lo_q));
  assign below     = sq_q < bsr_pkg::SqW'(tgt_q);
  assign stop      = in_window || (iter_q == IterMax);

  // Both candidate midpoints, selected once the compare settles
  assign sum_lo = {1'b0, lo_q} + {1'b0, x_q};
  assign sum_hi = {1'b0, x_q} + {1'b0, hi_q};

  // Sequencer, shared multiplier and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      done_q   <= 1'b0;
      conv_q   <= 1'b0;
      iter_q   <= '0;
      tol_q    <= bsr_pkg::TolResetVal;
      lo_q     <= '0;
      hi_q     <= '0;
      x_q      <= '0;
      sq_q     <= '0;
      tgt_q    <= '0;
      lim_hi_q <= '0;
      lim_lo_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_wr && (paddr == bsr_pkg::RegTolerance)) begin
        tol_q <= pwdata;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            lo_q     <= '0;
            hi_q     <= hi_init;
            iter_q   <= '0;
            tgt_q    <= tgt_new;
            lim_hi_q <= tgt_new + tol_ext;
            lim_lo_q <= (tgt_new > tol_ext) ? (tgt_new - tol_ext) : '0;
            if (value_i == '0) begin
              // exact hit at zero
              x_q    <= '0;
              conv_q <= 1'b1;
              done_q <= 1'b1;
            end else if (value_i == bsr_pkg::FixOne) begin
              // exact hit at one
              x_q    <= bsr_pkg::FixOne;
              conv_q <= 1'b1;
              done_q <= 1'b1;
            end else begin
              x_q     <= hi_init >> 1;
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          sq_q    <= bsr_pkg::SqW'(x_q) * bsr_pkg::SqW'(x_q);
          state_q <= StCmp;
        end
        StCmp: begin
          if (stop) begin
            conv_q  <= in_window;
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else begin
            // narrow the interval towards the root
            if (below) begin
              lo_q <= x_q;
              x_q  <= sum_hi[bsr_pkg::DataW:1];
            end else begin
              hi_q <= x_q;
              x_q  <= sum_lo[bsr_pkg::DataW:1];
            end
            iter_q  <= iter_q + 1'b1;
            state_q <= StMul;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = done_q;
  assign root_o       = x_q;
  assign low_bound_o  = lo_q;
  assign high_bound_o = hi_q;
  assign iterations_o = iter_q;
  assign converged_o  = conv_q;

`ifndef SYNTHESIS
  // A result always leaves the block free for the next command
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while still busy");

  // A zero radicand answers in the next cycle with a zero root
  a_zero_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (value_i == '0)) |=> (done_o && (root_o == '0)))
    else $error("zero radicand not answered at once");

  // Failing to converge only happens at the iteration cap
  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !converged_o) |-> (iterations_o == IterMax))
    else $error("unconverged result before the cap");

  // The root lies inside the final interval
  a_bracket : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((low_bound_o <= root_o) && (root_o <= high_bound_o)))
    else $error("root outside its bounds");
`endif

endmodule

// ===== tb/bsr_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bisection square root result checker
// Watches the command, result and APB ports of the block. Keeps its own
// copy of the tolerance register, predicts each root by interval halving
// and compares every result transfer field by field with the oldest one due.
// ----------------------------------------------------------------------------
module bsr_result_checker #(
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  input  logic                        busy,
  input  bsr_pkg::data_t              value_i,
  // result channel
  input  logic                        done_o,
  input  bsr_pkg::data_t              root_o,
  input  bsr_pkg::data_t              low_bound_o,
  input  bsr_pkg::data_t              high_bound_o,
  input  logic [bsr_pkg::IterW-1:0]   iterations_o,
  input  logic                        converged_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsr_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  // status towards the stimulus side
  output int unsigned                 error_count,
  output int unsigned                 pending_count
);

  typedef struct packed {
    bsr_pkg::data_t             radicand;
    bsr_pkg::data_t             root;
    bsr_pkg::data_t             low;
    bsr_pkg::data_t             high;
    logic [bsr_pkg::IterW-1:0]  steps;
    logic                       conv;
  } sqrt_result_t;

  bsr_pkg::data_t tolerance_q;
  sqrt_result_t   pending_roots [$];

  function automatic bsr_pkg::sq_t sq_distance(input bsr_pkg::sq_t a, input bsr_pkg::sq_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Halve [lo, hi] until the midpoint squared lies within the tolerance or the cap is hit
  function automatic sqrt_result_t bisect_sqrt(input bsr_pkg::data_t radicand,
                                               input bsr_pkg::data_t tol);
    bsr_pkg::sq_t target;
    bsr_pkg::sq_t lo;
    bsr_pkg::sq_t hi;
    bsr_pkg::sq_t mid;
    bsr_pkg::sq_t sq;
    int unsigned  steps;
    sqrt_result_t res;
    target = bsr_pkg::sq_t'(radicand) << bsr_pkg::FracW;
    lo     = '0;
    hi     = (radicand > bsr_pkg::FixOne) ? bsr_pkg::sq_t'(radicand)
                                          : bsr_pkg::sq_t'(bsr_pkg::FixOne);
    steps  = 0;
    if (target == '0) begin
      // exact hit at zero
      mid      = lo;
      res.conv = 1'b1;
    end else if (hi * hi == target) begin
      // exact hit at the upper end
      mid      = hi;
      res.conv = 1'b1;
    end else begin
      mid = (lo + hi) >> 1;
      sq  = mid * mid;
      while (sq_distance(sq, target) > bsr_pkg::sq_t'(tol) && steps < MAX_ITERATIONS) begin
        if (sq < target) begin
          lo = mid;
        end else begin
          hi = mid;
        end
        mid = (lo + hi) >> 1;
        sq  = mid * mid;
        steps++;
      end
      res.conv = (sq_distance(sq, target) <= bsr_pkg::sq_t'(tol));
    end
    res.radicand = radicand;
    res.root     = mid[bsr_pkg::DataW-1:0];
    res.low      = lo[bsr_pkg::DataW-1:0];
    res.high     = hi[bsr_pkg::DataW-1:0];
    res.steps    = bsr_pkg::IterW'(steps);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns ERROR %s", $time, msg);
    error_count++;
  endtask

  // Track the tolerance, retire results, then queue the newly accepted radicand
  always @(posedge clk_i or negedge rst_ni) begin
    sqrt_result_t want;
    if (!rst_ni) begin
      tolerance_q   = bsr_pkg::TolResetVal;
      pending_roots.delete();
      pending_count = 0;
      error_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == bsr_pkg::RegTolerance) begin
        tolerance_q = pwdata;
      end
      if (done_o === 1'b1) begin
        if (pending_roots.size() == 0) begin
          report_mismatch($sformatf("result transfer with none due: root %0h", root_o));
        end else begin
          want = pending_roots.pop_front();
          if (root_o !== want.root)
            report_mismatch($sformatf("radicand %0h root: got %0h want %0h",
                                      want.radicand, root_o, want.root));
          if (low_bound_o !== want.low)
            report_mismatch($sformatf("radicand %0h low_bound: got %0h want %0h",
                                      want.radicand, low_bound_o, want.low));
          if (high_bound_o !== want.high)
            report_mismatch($sformatf("radicand %0h high_bound: got %0h want %0h",
                                      want.radicand, high_bound_o, want.high));
          if (iterations_o !== want.steps)
            report_mismatch($sformatf("radicand %0h iterations: got %0d want %0d",
                                      want.radicand, iterations_o, want.steps));
          if (converged_o !== want.conv)
            report_mismatch($sformatf("radicand %0h converged: got %0b want %0b",
                                      want.radicand, converged_o, want.conv));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        pending_roots.push_back(bisect_sqrt(value_i, tolerance_q));
      end
      pending_count = pending_roots.size();
    end
  end

endmodule

// ===== tb/tb_bisection_square_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bisection square root testbench
// Drives radicands through the command port and retunes the tolerance over
// APB between phases: corners, a zero-tolerance set, then random phases at
// several tolerances and sender idle rates. A checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_bisection_square_root;

  localparam int unsigned MaxSteps     = 64;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned DrainCycles  = 2 * MaxSteps + 4;
  localparam int unsigned PhaseCount   = 6;
  localparam int unsigned PhaseItems   = 105;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  bsr_pkg::data_t            value_i;
  logic                      done_o;
  bsr_pkg::data_t            root_o;
  bsr_pkg::data_t            low_bound_o;
  bsr_pkg::data_t            high_bound_o;
  logic [bsr_pkg::IterW-1:0] iterations_o;
  logic                      converged_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [bsr_pkg::AddrW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  int unsigned      error_count;
  int unsigned      pending_count;
  int unsigned      idle_pct;
  int unsigned      idle_cycles;
  bsr_pkg::data_t   phase_tol [PhaseCount];

  int unsigned phase_idle [PhaseCount] = '{22, 22, 60, 60, 0, 0};

  bsr_pkg::data_t corner_radicands [12] = '{
    32'd0, 32'd4096, 32'd1, 32'd2, 32'd4095, 32'd4097, 32'd16384, 32'd9,
    32'hFFFE_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
  };

  bsr_pkg::data_t stall_radicands [8] = '{
    32'd1, 32'd2, 32'd3, 32'd4095, 32'd4097, 32'hFFFF_FFFF, 32'd0, 32'd4096
  };

  always #5 clk_i = ~clk_i;

  bisection_square_root #(
    .MAX_ITERATIONS (MaxSteps)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .done_o       (done_o),
    .root_o       (root_o),
    .low_bound_o  (low_bound_o),
    .high_bound_o (high_bound_o),
    .iterations_o (iterations_o),
    .converged_o  (converged_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bsr_result_checker #(
    .MAX_ITERATIONS (MaxSteps)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .done_o        (done_o),
    .root_o        (root_o),
    .low_bound_o   (low_bound_o),
    .high_bound_o  (high_bound_o),
    .iterations_o  (iterations_o),
    .converged_o   (converged_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Full-range, small, exact-root, near-one, scaled and near-max radicands
  function automatic bsr_pkg::data_t pick_radicand();
    int unsigned k;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 8191);
      2: begin
        k = $urandom_range(0, 65535);
        return bsr_pkg::data_t'(k * k);
      end
      3: return $urandom_range(4088, 4104);
      4: return $urandom >> $urandom_range(0, 31);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
    endcase
  endfunction

  // Offer one radicand and hold it until the transfer; call at a falling edge
  task automatic issue_radicand(input bsr_pkg::data_t val);
    int unsigned gap;
    bit          taken;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 8);
    end
    if (gap != 0) begin
      start   <= 1'b0;
      value_i <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    value_i <= val;
    taken   = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      @(negedge clk_i);
    end
  endtask

  // Drop the command, drain every due result, then write the tolerance
  task automatic retune_tolerance(input bsr_pkg::data_t tol);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bsr_pkg::RegTolerance;
    pwdata  <= tol;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stimulus
  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    value_i  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 0;
    phase_tol[0] = bsr_pkg::TolResetVal;
    phase_tol[1] = 32'hFFFF_FFFF;
    phase_tol[2] = 32'd0;
    phase_tol[3] = $urandom_range(1, 65535);
    phase_tol[4] = $urandom;
    phase_tol[5] = 32'd1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners at the reset tolerance
    foreach (corner_radicands[i]) issue_radicand(corner_radicands[i]);

    // zero tolerance: exact hits, stalls and the iteration cap
    retune_tolerance(32'd0);
    foreach (stall_radicands[i]) issue_radicand(stall_radicands[i]);

    // random phases across tolerances and idle rates
    for (int p = 0; p < PhaseCount; p++) begin
      retune_tolerance(phase_tol[p]);
      idle_pct = phase_idle[p];
      repeat (PhaseItems) issue_radicand(pick_radicand());
    end

    // drain and settle
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("bisection_square_root: match");
    end else begin
      $display("bisection_square_root: mismatch");
    end
    $finish;
  end

  // Watchdog: end the run after a long stretch without any transfer
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t ns ERROR no transfer for %0d cycles", $time, StallLimit);
    $display("bisection_square_root: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bsr_pkg.sv
hdl/bisection_square_root.sv
tb/bsr_result_checker.sv
tb/tb_bisection_square_root.sv
